// ===== src/bsd_pkg.sv =====
package bsd_pkg;

    localparam int NUM_STEPS_DEFAULT = 16;
    localparam int LEVEL_W           = 8;
    localparam int ACTION_W          = 2;
    localparam int STEP_NOW_W        = 5;
    // Rounding bias for level * steps / 255 (half of the divisor, rounded down).
    localparam int ROUND_BIAS        = 127;
    localparam int UPC_W             = 3;

    typedef logic [UPC_W-1:0] upc_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_OFF   = 2'd0,
        ACT_START = 2'd1,
        ACT_PULSE = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_SAME,
        COND_TGT_NZ,
        COND_CUR_NZ,
        COND_CNT_ZERO,
        COND_CNT_MORE
    } cond_t;

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_ZERO,
        CUR_FULL,
        CUR_DEC
    } cur_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_LOAD,
        CNT_DEC
    } cnt_op_t;

    // Microcode addresses.
    localparam upc_t UA_WAIT   = 3'd0;
    localparam upc_t UA_SAME   = 3'd1;
    localparam upc_t UA_OFFCHK = 3'd2;
    localparam upc_t UA_OFF    = 3'd3;
    localparam upc_t UA_LOAD   = 3'd4;
    localparam upc_t UA_START  = 3'd5;
    localparam upc_t UA_LOOP   = 3'd6;
    localparam upc_t UA_PULSE  = 3'd7;

    typedef struct packed {
        cond_t   cond;
        upc_t    jmp;
        logic    accept;
        logic    emit;
        action_t act;
        cur_op_t cur_op;
        cnt_op_t cnt_op;
    } ucode_t;

    typedef struct packed {
        ucode_t uc;
        logic   go;
    } ctl_t;

    typedef struct packed {
        logic same;
        logic tgt_nz;
        logic cur_nz;
        logic cnt_zero;
        logic cnt_more;
        logic out_free;
    } stat_t;

    // The control program. When the condition holds the sequencer jumps,
    // otherwise it moves to the next address (the last address wraps to the
    // wait step).
    function automatic ucode_t ucode_rom(input upc_t addr);
        ucode_t w;
        w = '{cond: COND_ALWAYS, jmp: UA_WAIT, accept: 1'b0, emit: 1'b0,
              act: ACT_OFF, cur_op: CUR_HOLD, cnt_op: CNT_HOLD};
        unique case (addr)
            UA_WAIT: begin
                w.cond   = COND_NO_INPUT;
                w.jmp    = UA_WAIT;
                w.accept = 1'b1;
            end
            UA_SAME: begin
                w.cond = COND_SAME;
                w.jmp  = UA_WAIT;
            end
            UA_OFFCHK: begin
                w.cond = COND_TGT_NZ;
                w.jmp  = UA_LOAD;
            end
            UA_OFF: begin
                w.cond   = COND_ALWAYS;
                w.jmp    = UA_WAIT;
                w.emit   = 1'b1;
                w.act    = ACT_OFF;
                w.cur_op = CUR_ZERO;
            end
            UA_LOAD: begin
                w.cond   = COND_CUR_NZ;
                w.jmp    = UA_LOOP;
                w.cnt_op = CNT_LOAD;
            end
            UA_START: begin
                w.cond   = COND_CNT_ZERO;
                w.jmp    = UA_WAIT;
                w.emit   = 1'b1;
                w.act    = ACT_START;
                w.cur_op = CUR_FULL;
            end
            UA_LOOP: begin
                w.cond = COND_CNT_ZERO;
                w.jmp  = UA_WAIT;
            end
            UA_PULSE: begin
                w.cond   = COND_CNT_MORE;
                w.jmp    = UA_PULSE;
                w.emit   = 1'b1;
                w.act    = ACT_PULSE;
                w.cur_op = CUR_DEC;
                w.cnt_op = CNT_DEC;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== src/backlight_step_dimmer.sv =====
// Backlight step dimmer for a single-wire, pulse-count backlight driver.
// The input channel (s_valid, s_ready, s_level) carries one brightness
// request per transaction, 0 for off up to 255 for full. The request is
// rounded to a step from 0 to NUM_STEPS and compared with the step the
// driver holds now. The result channel (m_valid, m_ready, m_action,
// m_step_now, m_last) carries one pin action per transaction: drive low and
// hold (off), drive high (start), or one low-high pulse that moves the
// driver down one step. m_last marks the final action of a request; an
// unchanged step produces no transactions at all.
// A small microcode program steps through each request, one control word
// per cycle while no emitting step waits on the output register. An
// unchanged request ends after the compare step, an off request after the
// off action; otherwise the program loads the pulse count, emits a start
// when the light is off, then the pulses. The next request is taken only
// back on the wait step. The pulse step issues one action per cycle while
// the output register is free.
// Reset (aresetn low at a clock edge) returns the sequencer to its wait
// step, empties the output register and records the light as off.
// When the receiver stalls, the pending action holds in the output register
// and the program waits on its emitting step; no action is lost or repeated.
module backlight_step_dimmer #(
    parameter int NUM_STEPS = bsd_pkg::NUM_STEPS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [bsd_pkg::LEVEL_W-1:0]      s_level,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [bsd_pkg::ACTION_W-1:0]     m_action,
    output logic [bsd_pkg::STEP_NOW_W-1:0]   m_step_now,
    output logic                             m_last
);

    bsd_pkg::ctl_t  ctl;
    bsd_pkg::stat_t stat;

    // The sequencer owns the program counter and the control store.
    bsd_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .stat    (stat),
        .ctl     (ctl)
    );

    // The datapath holds the target, the current step, the pulse count and
    // the output register that decouples the two channels.
    bsd_datapath #(
        .NUM_STEPS (NUM_STEPS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_level    (s_level),
        .ctl        (ctl),
        .stat       (stat),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_action   (m_action),
        .m_step_now (m_step_now),
        .m_last     (m_last)
    );

    // A new request is taken only on the wait step of the program, and
    // never while reset is held.
    assign s_ready = ctl.uc.accept && aresetn;

endmodule

// ===== src/bsd_sequencer.sv =====
module bsd_sequencer (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  bsd_pkg::stat_t stat,
    output bsd_pkg::ctl_t  ctl
);

    bsd_pkg::upc_t   upc_reg;
    bsd_pkg::upc_t   upc_next;
    bsd_pkg::ucode_t word;
    logic            cond_true;
    logic            go;

    assign word = bsd_pkg::ucode_rom(upc_reg);

    always_comb begin
        unique case (word.cond)
            bsd_pkg::COND_ALWAYS:   cond_true = 1'b1;
            bsd_pkg::COND_NO_INPUT: cond_true = !s_valid;
            bsd_pkg::COND_SAME:     cond_true = stat.same;
            bsd_pkg::COND_TGT_NZ:   cond_true = stat.tgt_nz;
            bsd_pkg::COND_CUR_NZ:   cond_true = stat.cur_nz;
            bsd_pkg::COND_CNT_ZERO: cond_true = stat.cnt_zero;
            bsd_pkg::COND_CNT_MORE: cond_true = stat.cnt_more;
            default:                cond_true = 1'b1;
        endcase
    end

    // An emitting step holds until the output register can take the result.
    assign go = !word.emit || stat.out_free;

    always_comb begin
        upc_next = upc_reg;
        if (go) begin
            upc_next = cond_true ? word.jmp : upc_reg + bsd_pkg::upc_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= bsd_pkg::UA_WAIT;
        end else begin
            upc_reg <= upc_next;
        end
    end

    assign ctl.uc = word;
    assign ctl.go = go;

    a_accept_leaves_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (word.accept && s_valid) |=> (upc_reg == bsd_pkg::UA_SAME))
        else $error("sequencer did not leave the wait step after a transaction");

endmodule

// ===== src/bsd_datapath.sv =====
module bsd_datapath #(
    parameter int NUM_STEPS = bsd_pkg::NUM_STEPS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic [bsd_pkg::LEVEL_W-1:0]      s_level,
    input  bsd_pkg::ctl_t                    ctl,
    output bsd_pkg::stat_t                   stat,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [bsd_pkg::ACTION_W-1:0]     m_action,
    output logic [bsd_pkg::STEP_NOW_W-1:0]   m_step_now,
    output logic                             m_last
);

    localparam int SW = $clog2(NUM_STEPS + 1);
    localparam int XW = SW + bsd_pkg::LEVEL_W + 1;
    localparam int PW = SW + 1;
    localparam logic [SW-1:0] FULL = SW'(NUM_STEPS);

    logic [SW-1:0] tgt_reg, tgt_next;
    logic [SW-1:0] cur_reg, cur_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic          m_valid_reg, m_valid_next;
    logic [bsd_pkg::ACTION_W-1:0]   m_action_reg, m_action_next;
    logic [bsd_pkg::STEP_NOW_W-1:0] m_step_now_reg, m_step_now_next;
    logic          m_last_reg, m_last_next;

    logic [XW-1:0] scaled;
    logic [XW-1:0] quot;
    logic [SW-1:0] tgt_calc;
    logic [SW-1:0] cur_eff;
    logic [SW-1:0] cur_dec;
    logic [PW-1:0] span;
    logic [SW-1:0] pulses;
    logic          fire;
    logic          last_calc;

    // Divide by 255 as (x + (x >> 8) + 1) >> 8, exact for these ranges.
    assign scaled = XW'(s_level) * XW'(NUM_STEPS) + XW'(bsd_pkg::ROUND_BIAS);
    assign quot   = (scaled + (scaled >> bsd_pkg::LEVEL_W) + XW'(1)) >> bsd_pkg::LEVEL_W;
    assign tgt_calc = (quot > XW'(NUM_STEPS)) ? FULL : SW'(quot);

    assign cur_eff = (cur_reg == '0) ? FULL : cur_reg;
    assign span    = PW'(NUM_STEPS) + PW'(cur_eff) - PW'(tgt_reg);
    assign pulses  = (span >= PW'(NUM_STEPS)) ? SW'(span - PW'(NUM_STEPS)) : SW'(span);
    assign cur_dec = (cur_reg <= SW'(1)) ? FULL : cur_reg - SW'(1);

    assign fire = ctl.go && ctl.uc.emit;

    always_comb begin
        tgt_next = tgt_reg;
        if (ctl.uc.accept && s_valid) begin
            tgt_next = tgt_calc;
        end
    end

    always_comb begin
        cur_next = cur_reg;
        if (ctl.go) begin
            unique case (ctl.uc.cur_op)
                bsd_pkg::CUR_HOLD: cur_next = cur_reg;
                bsd_pkg::CUR_ZERO: cur_next = '0;
                bsd_pkg::CUR_FULL: cur_next = FULL;
                bsd_pkg::CUR_DEC:  cur_next = cur_dec;
                default:           cur_next = cur_reg;
            endcase
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (ctl.go) begin
            unique case (ctl.uc.cnt_op)
                bsd_pkg::CNT_HOLD: cnt_next = cnt_reg;
                bsd_pkg::CNT_LOAD: cnt_next = pulses;
                bsd_pkg::CNT_DEC:  cnt_next = cnt_reg - SW'(1);
                default:           cnt_next = cnt_reg;
            endcase
        end
    end

    always_comb begin
        unique case (ctl.uc.act)
            bsd_pkg::ACT_OFF:   last_calc = 1'b1;
            bsd_pkg::ACT_START: last_calc = (cnt_reg == '0);
            bsd_pkg::ACT_PULSE: last_calc = (cnt_reg == SW'(1));
            default:            last_calc = 1'b1;
        endcase
    end

    always_comb begin
        m_valid_next    = m_valid_reg && !m_ready;
        m_action_next   = m_action_reg;
        m_step_now_next = m_step_now_reg;
        m_last_next     = m_last_reg;
        if (fire) begin
            m_valid_next    = 1'b1;
            m_action_next   = ctl.uc.act;
            m_step_now_next = bsd_pkg::STEP_NOW_W'(cur_next);
            m_last_next     = last_calc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cur_reg     <= cur_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tgt_reg        <= tgt_next;
        cnt_reg        <= cnt_next;
        m_action_reg   <= m_action_next;
        m_step_now_reg <= m_step_now_next;
        m_last_reg     <= m_last_next;
    end

    assign stat.same     = (tgt_reg == cur_reg);
    assign stat.tgt_nz   = (tgt_reg != '0);
    assign stat.cur_nz   = (cur_reg != '0);
    assign stat.cnt_zero = (cnt_reg == '0);
    assign stat.cnt_more = (cnt_reg > SW'(1));
    assign stat.out_free = !m_valid_reg || m_ready;

    assign m_valid    = m_valid_reg;
    assign m_action   = m_action_reg;
    assign m_step_now = m_step_now_reg;
    assign m_last     = m_last_reg;

    a_cur_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_reg <= FULL)
        else $error("current step above the top step");

    a_pulse_needs_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && ctl.uc.act == bsd_pkg::ACT_PULSE) |-> (cnt_reg != '0))
        else $error("pulse emitted with no pulses left");

    a_off_is_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && ctl.uc.act == bsd_pkg::ACT_OFF) |=> (m_last_reg && m_step_now_reg == '0))
        else $error("off action must be final and show step zero");

endmodule

// ===== tb/bsd_pin_action_checker.sv =====
// Watches both channels of the backlight step dimmer. Every accepted request
// is turned into the pin actions the driver should see, and every accepted
// action is compared with the oldest one still waiting.
module bsd_pin_action_checker #(
    parameter int NUM_STEPS = bsd_pkg::NUM_STEPS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [bsd_pkg::LEVEL_W-1:0]      s_level,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [bsd_pkg::ACTION_W-1:0]     m_action,
    input  logic [bsd_pkg::STEP_NOW_W-1:0]   m_step_now,
    input  logic                             m_last,
    output int                               mismatch_count,
    output int                               outstanding
);
    import bsd_pkg::*;

    localparam int LEVEL_MAX = 255;
    localparam int SHOWN_MAX = 10;

    typedef struct packed {
        action_t                act;
        logic [STEP_NOW_W-1:0]  step;
        logic                   last;
    } pin_action_t;

    pin_action_t pending_pin_actions[$];
    int          held_step;

    function automatic void queue_pin_action(input action_t act, input int step,
                                             input logic last_flag);
        pin_action_t a;
        a.act  = act;
        a.step = step[STEP_NOW_W-1:0];
        a.last = last_flag;
        pending_pin_actions.push_back(a);
    endfunction

    // Rounds the request to a step and queues the actions that walk the
    // driver from the held step to that step.
    function automatic void predict_pin_actions(input logic [LEVEL_W-1:0] level);
        int target;
        int pos;
        int pulses;
        target = (int'(level) * NUM_STEPS + ROUND_BIAS) / LEVEL_MAX;
        if (target > NUM_STEPS) begin
            target = NUM_STEPS;
        end
        if (target == held_step) begin
            return;
        end
        if (target == 0) begin
            queue_pin_action(ACT_OFF, 0, 1'b1);
            held_step = 0;
            return;
        end
        pos = (held_step > NUM_STEPS) ? NUM_STEPS : held_step;
        if (pos == 0) begin
            pos    = NUM_STEPS;
            pulses = (NUM_STEPS + pos - target) % NUM_STEPS;
            queue_pin_action(ACT_START, pos, pulses == 0);
        end else begin
            pulses = (NUM_STEPS + pos - target) % NUM_STEPS;
        end
        for (int i = 0; i < pulses; i++) begin
            pos = (pos <= 1) ? NUM_STEPS : pos - 1;
            queue_pin_action(ACT_PULSE, pos, i + 1 == pulses);
        end
        held_step = target;
    endfunction

    always @(posedge aclk) begin : watch
        pin_action_t want;
        if (!aresetn) begin
            pending_pin_actions.delete();
            held_step      = 0;
            mismatch_count = 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_pin_actions(s_level);
            end
            if (m_valid && m_ready) begin
                if (pending_pin_actions.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_MAX) begin
                        $display("unexpected pin action: action %0d step %0d last %0d",
                                 m_action, m_step_now, m_last);
                    end
                end else begin
                    want = pending_pin_actions.pop_front();
                    if (m_action !== want.act || m_step_now !== want.step ||
                        m_last !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= SHOWN_MAX) begin
                            $display("pin action mismatch: expected action %0d step %0d last %0d",
                                     want.act, want.step, want.last);
                            $display("    got action %0d step %0d last %0d",
                                     m_action, m_step_now, m_last);
                        end
                    end
                end
            end
        end
        outstanding <= pending_pin_actions.size();
    end

endmodule

// ===== tb/backlight_step_dimmer_test.sv =====
// Stimulus and verdict for the backlight step dimmer. The checker beside the
// block does all prediction and comparison; this module only offers requests,
// paces the result channel and decides pass or fail at the end.
module backlight_step_dimmer_test;
    import bsd_pkg::*;

    localparam int NUM_STEPS    = NUM_STEPS_DEFAULT;
    localparam int RANDOM_ITEMS = 78;
    localparam int BURST_ITEMS  = 8;
    localparam int LONG_STALL   = 400;
    // A request with a start and fifteen pulses keeps the block busy the
    // longest; the settle time after draining covers that twice.
    localparam int SETTLE       = 50;
    localparam int DRAIN_LIMIT  = 20000;

    logic                    aclk       = 1'b0;
    logic                    aresetn    = 1'b0;
    logic                    s_valid    = 1'b0;
    logic                    s_ready;
    logic [LEVEL_W-1:0]      s_level    = '0;
    logic                    m_valid;
    logic                    m_ready    = 1'b0;
    logic [ACTION_W-1:0]     m_action;
    logic [STEP_NOW_W-1:0]   m_step_now;
    logic                    m_last;

    int mismatch_count;
    int outstanding;

    // While calm is set neither side draws an idle gap, so the block runs at full rate.
    bit calm          = 1'b0;
    // A request to the receiver for one long hold-off.
    bit rx_long_stall = 1'b0;

    logic [LEVEL_W-1:0] last_level = '0;

    // Directed requests. Starting from off: an unchanged off request, a full
    // request while off (start action only), off, a mid level from off (start
    // plus pulses), the lowest nonzero step with the level just below it,
    // a start that needs fifteen pulses, a single pulse that wraps from step
    // one back to full, repeats that must emit nothing, and the field extremes.
    logic [LEVEL_W-1:0] directed_levels [0:23] = '{
        8'd0,   8'd255, 8'd0,   8'd128, 8'd120, 8'd135,
        8'd8,   8'd7,   8'd16,  8'd255, 8'd240, 8'd255,
        8'd255, 8'd1,   8'd127, 8'd128, 8'd254, 8'd85,
        8'd170, 8'd15,  8'd16,  8'd0,   8'd0,   8'd170
    };

    always #5 aclk = ~aclk;

    backlight_step_dimmer #(
        .NUM_STEPS (NUM_STEPS)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_level    (s_level),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_action   (m_action),
        .m_step_now (m_step_now),
        .m_last     (m_last)
    );

    bsd_pin_action_checker #(
        .NUM_STEPS (NUM_STEPS)
    ) i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_level        (s_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_action       (m_action),
        .m_step_now     (m_step_now),
        .m_last         (m_last),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // Offers one request and returns at the edge where the transaction takes
    // place. The gap is drawn here so that idle cycles fall before requests
    // that find the block in any phase of its work. When the next call keeps
    // valid high, it sets valid once more with the new level, so valid gets one
    // assignment per edge.
    task automatic offer_level(input logic [LEVEL_W-1:0] level);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_level    <= level;
        last_level  = level;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Waits until the checker holds no more expected actions, then lets the
    // block settle, since an unchanged request can still be in flight.
    task automatic drain_actions();
        int guard;
        guard = 0;
        @(posedge aclk);
        while (outstanding != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Draws a request. Half are uniform over the field, some repeat the
    // previous level so that the step does not change, some are off or full,
    // and some sit right at a rounding boundary between two steps.
    function automatic logic [LEVEL_W-1:0] draw_level();
        int t;
        int b;
        unique case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return last_level;
            4: begin
                t = $urandom_range(1, NUM_STEPS);
                b = (255 * t - 112) / NUM_STEPS;
                return LEVEL_W'(b - int'($urandom_range(0, 1)));
            end
            default: return LEVEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    // The receiver draws its own stall before every result and, on request,
    // holds off for a long stretch counted here in cycles. During that time
    // the block's output register stays full and its input backs up.
    initial begin : receiver
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (rx_long_stall) begin
                rx_long_stall = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
            end
            stall = calm ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_levels[i]) begin
            offer_level(directed_levels[i]);
        end
        s_valid <= 1'b0;

        // The sender pauses here until every expected action has come back.
        drain_actions();

        // Long receiver hold-off while requests keep coming back to back.
        // Each request changes the step, so the block has actions to emit
        // and stalls its input once the output side is full.
        rx_long_stall = 1'b1;
        calm          = 1'b1;
        for (int i = 0; i < BURST_ITEMS; i++) begin
            offer_level((i % 2 == 0) ? LEVEL_W'($urandom_range(0, 120))
                                     : LEVEL_W'($urandom_range(136, 255)));
        end
        calm = 1'b0;

        // Random part, with one stretch in the middle where neither side idles.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm = (i >= 40 && i < 60);
            offer_level(draw_level());
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        drain_actions();

        if (mismatch_count == 0 && outstanding == 0) begin
            $display("backlight_step_dimmer_test: done, clean");
        end else begin
            $display("backlight_step_dimmer_test: done, errors");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run: every request with a full
    // run of sixteen actions, each waiting out the longest receiver stall.
    initial begin
        #3000000;
        $display("backlight_step_dimmer_test: done, errors");
        $finish;
    end

endmodule
